FILE: design/sare_pkg.sv
// Shared types and constants for the stereo attack/release envelope.
package sare_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int SAMPLE_BITS = 24;
  localparam int STEP_BITS   = 25;
  localparam int GAIN_BITS   = 17;
  localparam int GAIN_FRAC   = 16;
  localparam int MUL_BITS    = 26;
  localparam int PROD_BITS   = 2 * MUL_BITS;
  localparam int PROD_A_BITS = COUNT_BITS + GAIN_BITS;
  localparam int A_LO_BITS   = 19;
  localparam int A_HI_BITS   = PROD_A_BITS - A_LO_BITS;
  localparam int ACC_BITS    = PROD_A_BITS + STEP_BITS;
  localparam int DEC_SHIFT   = 24;
  localparam int ATT_SHIFT   = 8;

  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1 << GAIN_FRAC);

  localparam logic [1:0] CFG_ATTACK_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_RELEASE_LENGTH = 2'd1;
  localparam logic [1:0] CFG_ATTACK_STEP    = 2'd2;
  localparam logic [1:0] CFG_RELEASE_STEP   = 2'd3;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2
  } kind_e;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_AGAIN = 12'b0000_0000_0010,
    ST_ASAT  = 12'b0000_0000_0100,
    ST_RMUL0 = 12'b0000_0000_1000,
    ST_RMUL1 = 12'b0000_0001_0000,
    ST_RMUL2 = 12'b0000_0010_0000,
    ST_RADD  = 12'b0000_0100_0000,
    ST_RGAIN = 12'b0000_1000_0000,
    ST_SQ    = 12'b0001_0000_0000,
    ST_CUBE  = 12'b0010_0000_0000,
    ST_SIDE  = 12'b0100_0000_0000,
    ST_WB    = 12'b1000_0000_0000
  } state_e;

  typedef struct packed {
    logic accept;
    logic attack;
    logic release_ramp;
    logic wb_ok;
  } path_t;

endpackage

FILE: design/sare_mul.sv
// Shared signed multiplier with registered product.
module sare_mul import sare_pkg::*; (
  input  logic                        clk_i,
  input  logic signed [MUL_BITS-1:0]  a_i,
  input  logic signed [MUL_BITS-1:0]  b_i,
  output logic signed [PROD_BITS-1:0] prod_o
);

  logic signed [PROD_BITS-1:0] prod_d, prod_q;

  assign prod_d = a_i * b_i;
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

endmodule

FILE: design/sare_seq.sv
// Sequencer that steps one item through the shared multiplier.
module sare_seq import sare_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  path_t  path_i,
  output state_e state_o
);

  state_e st_d, st_q;
  logic   side_q, side_d;

  assign state_o = st_q;

  always_comb begin
    st_d   = st_q;
    side_d = side_q;
    unique case (st_q)
      ST_IDLE: begin
        side_d = 1'b0;
        if (path_i.accept) begin
          if (path_i.attack) st_d = ST_AGAIN;
          else if (path_i.release_ramp) st_d = ST_RMUL0;
          else st_d = ST_WB;
        end
      end
      ST_AGAIN: st_d = ST_ASAT;
      ST_ASAT:  st_d = ST_SQ;
      ST_RMUL0: st_d = ST_RMUL1;
      ST_RMUL1: st_d = ST_RMUL2;
      ST_RMUL2: st_d = ST_RADD;
      ST_RADD:  st_d = ST_RGAIN;
      ST_RGAIN: st_d = ST_SQ;
      ST_SQ:    st_d = ST_CUBE;
      ST_CUBE:  st_d = ST_SIDE;
      ST_SIDE: begin
        // left, right, then retire the right product
        if (side_q) st_d = ST_WB;
        side_d = 1'b1;
      end
      ST_WB: begin
        if (path_i.wb_ok) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      side_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      side_q <= side_d;
    end
  end

endmodule

FILE: design/stereo_attack_release_envelope.sv
// Stereo attack/release envelope with cubic gain: top level.
// Takes start, stop and stereo sample beats and returns one result beat for each.
// Start, stop, pass-through and muted samples go from idle straight to writeback. A
// sample on the attack ramp first takes the ramp gain and its saturation; one on the
// release ramp the partial products, an add and the gain; both then square, cube and
// scale each side. The single 26x26 multiplier sets this order, since every product
// goes through it in turn: the ramp gain (or three release partial products), square,
// cube, left and right. Input is taken only while the sequencer is idle. A finished
// result waits in the output register, so the next beat can be accepted while the
// previous result is stalled. A second finished result holds the sequencer in
// writeback until the first one leaves. Configuration writes are always ready and are
// expected only while the block is idle.
module stereo_attack_release_envelope import sare_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    kind_i,
  input  logic signed [SAMPLE_BITS-1:0] left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0] right_sample_i,
  input  logic                          instant_stop_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] left_out_o,
  output logic signed [SAMPLE_BITS-1:0] right_out_o,
  output logic                          attack_active_o,
  output logic                          release_active_o,
  output logic                          stop_request_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [STEP_BITS-1:0]          cfg_data_i
);

  state_e st;
  path_t  path;
  logic   in_acc, wb_ok;

  logic [COUNT_BITS-1:0] alen_q, rlen_q;
  logic [STEP_BITS-1:0]  astep_q, rstep_q;

  logic                  in_attack_q, in_release_q, rdone_q;
  logic [COUNT_BITS-1:0] acount_q, rcount_q;
  logic [GAIN_BITS-1:0]  held_q;

  logic signed [SAMPLE_BITS-1:0] left_q, right_q, lo_q, ro_q;
  logic                          stop_q, ramp_att_q, side_q;
  logic [GAIN_BITS-1:0]          gain_q, g3_q;
  logic [A_HI_BITS-1:0]          a_hi_q;
  logic [ACC_BITS-1:0]           acc_q;

  logic signed [MUL_BITS-1:0]  mul_a, mul_b;
  logic signed [PROD_BITS-1:0] prod;

  logic                          out_valid_q, out_att_q, out_rel_q, out_stop_q;
  logic signed [SAMPLE_BITS-1:0] out_lo_q, out_ro_q;

  logic [PROD_A_BITS-1:0]         att_raw;
  logic [GAIN_BITS-1:0]           att_gain, rel_gain;
  logic [ACC_BITS-DEC_SHIFT-1:0]  dec;
  logic [COUNT_BITS-1:0]          acount_inc, rcount_inc;
  logic signed [SAMPLE_BITS-1:0]  scaled;

  logic                          ro_take_q;
  logic signed [SAMPLE_BITS-1:0] ro_now;

  assign in_stall_o  = (st != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign wb_ok       = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign path.accept       = in_acc;
  assign path.attack       = (kind_i == KIND_SAMPLE) && in_attack_q;
  assign path.release_ramp = (kind_i == KIND_SAMPLE) && !in_attack_q && in_release_q && !rdone_q;
  assign path.wb_ok        = wb_ok;

  sare_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .path_i  (path),
    .state_o (st)
  );

  sare_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st)
      ST_AGAIN: begin
        mul_a = MUL_BITS'(acount_q);
        mul_b = MUL_BITS'(astep_q);
      end
      ST_RMUL0: begin
        mul_a = MUL_BITS'(rcount_q);
        mul_b = MUL_BITS'(held_q);
      end
      ST_RMUL1: begin
        mul_a = MUL_BITS'(prod[A_LO_BITS-1:0]);
        mul_b = MUL_BITS'(rstep_q);
      end
      ST_RMUL2: begin
        mul_a = MUL_BITS'(a_hi_q);
        mul_b = MUL_BITS'(rstep_q);
      end
      ST_SQ: begin
        mul_a = MUL_BITS'(gain_q);
        mul_b = MUL_BITS'(gain_q);
      end
      ST_CUBE: begin
        mul_a = MUL_BITS'(prod[GAIN_FRAC+GAIN_BITS-1:GAIN_FRAC]);
        mul_b = MUL_BITS'(gain_q);
      end
      ST_SIDE: begin
        if (!side_q) begin
          mul_a = MUL_BITS'(left_q);
          mul_b = MUL_BITS'(prod[GAIN_FRAC+GAIN_BITS-1:GAIN_FRAC]);
        end else begin
          mul_a = MUL_BITS'(right_q);
          mul_b = MUL_BITS'(g3_q);
        end
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // attack gain saturates at 1.0, release gain clamps at zero
  assign att_raw  = prod[ATT_SHIFT+PROD_A_BITS-1:ATT_SHIFT];
  assign att_gain = (att_raw > PROD_A_BITS'(GAIN_ONE)) ? GAIN_ONE : att_raw[GAIN_BITS-1:0];
  assign dec      = acc_q[ACC_BITS-1:DEC_SHIFT];
  assign rel_gain = (dec >= (ACC_BITS-DEC_SHIFT)'(held_q)) ? '0
                  : held_q - dec[GAIN_BITS-1:0];
  assign scaled   = prod[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];
  assign acount_inc = acount_q + COUNT_BITS'(1);
  assign rcount_inc = rcount_q + COUNT_BITS'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alen_q  <= '0;
      rlen_q  <= '0;
      astep_q <= '0;
      rstep_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ATTACK_LENGTH:  alen_q  <= cfg_data_i[COUNT_BITS-1:0];
        CFG_RELEASE_LENGTH: rlen_q  <= cfg_data_i[COUNT_BITS-1:0];
        CFG_ATTACK_STEP:    astep_q <= cfg_data_i;
        CFG_RELEASE_STEP:   rstep_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_attack_q  <= 1'b0;
      in_release_q <= 1'b0;
      rdone_q      <= 1'b0;
      acount_q     <= '0;
      rcount_q     <= '0;
      held_q       <= '0;
      stop_q       <= 1'b0;
      ramp_att_q   <= 1'b0;
      side_q       <= 1'b0;
    end else begin
      unique case (st)
        ST_IDLE: begin
          side_q <= 1'b0;
          if (in_acc) begin
            stop_q     <= (kind_i == KIND_STOP) && ((rlen_q == '0) || instant_stop_i);
            ramp_att_q <= in_attack_q;
            if (kind_i == KIND_START) begin
              if (alen_q != '0) begin
                acount_q    <= '0;
                in_attack_q <= 1'b1;
              end
              in_release_q <= 1'b0;
              rdone_q      <= 1'b0;
            end else if (kind_i == KIND_STOP) begin
              if (rlen_q != '0 && !instant_stop_i) begin
                if (!in_release_q) begin
                  if (alen_q == '0) held_q <= GAIN_ONE;
                  rcount_q     <= '0;
                  in_release_q <= 1'b1;
                  rdone_q      <= 1'b0;
                end
              end else begin
                held_q       <= '0;
                in_release_q <= 1'b1;
                rdone_q      <= 1'b1;
              end
              in_attack_q <= 1'b0;
            end
          end
        end
        ST_ASAT: held_q <= att_gain;
        ST_SIDE: begin
          side_q <= 1'b1;
          if (side_q) begin
            if (ramp_att_q) begin
              acount_q <= acount_inc;
              if (acount_inc >= alen_q) in_attack_q <= 1'b0;
            end else begin
              rcount_q <= rcount_inc;
              if (({1'b0, rcount_inc} + (COUNT_BITS+1)'(1)) >= {1'b0, rlen_q}) begin
                held_q  <= '0;
                rdone_q <= 1'b1;
                stop_q  <= 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload path
  always_ff @(posedge clk_i) begin
    unique case (st)
      ST_IDLE: begin
        left_q  <= left_sample_i;
        right_q <= right_sample_i;
        if ((kind_i == KIND_SAMPLE) && !in_attack_q && !in_release_q) begin
          lo_q <= left_sample_i;
          ro_q <= right_sample_i;
        end else begin
          lo_q <= '0;
          ro_q <= '0;
        end
      end
      ST_ASAT:  gain_q <= att_gain;
      ST_RMUL1: a_hi_q <= prod[PROD_A_BITS-1:A_LO_BITS];
      ST_RMUL2: acc_q  <= ACC_BITS'(prod[A_LO_BITS+STEP_BITS-1:0]);
      ST_RADD:  acc_q  <= acc_q + {prod[ACC_BITS-A_LO_BITS-1:0], {A_LO_BITS{1'b0}}};
      ST_RGAIN: gain_q <= rel_gain;
      ST_SIDE: begin
        if (!side_q) begin
          g3_q <= prod[GAIN_FRAC+GAIN_BITS-1:GAIN_FRAC];
        end else begin
          lo_q <= scaled;
        end
      end
      // the right product is held for the output while WB is stalled
      ST_WB: ro_q <= ro_now;
      default: ;
    endcase
  end

  // right product lands the cycle after the side pass; capture it on entry to WB
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ro_take_q <= 1'b0;
    end else begin
      ro_take_q <= (st == ST_SIDE) && side_q;
    end
  end

  assign ro_now = ro_take_q ? scaled : ro_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((st == ST_WB) && wb_ok) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((st == ST_WB) && wb_ok) begin
      out_lo_q   <= lo_q;
      out_ro_q   <= ro_now;
      out_att_q  <= in_attack_q;
      out_rel_q  <= in_release_q;
      out_stop_q <= stop_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign left_out_o       = out_lo_q;
  assign right_out_o      = out_ro_q;
  assign attack_active_o  = out_att_q;
  assign release_active_o = out_rel_q;
  assign stop_request_o   = out_stop_q;

`ifndef SYNTHESIS
  a_one_ramp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_attack_q && in_release_q))
    else $error("attack and release ramps both active");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= GAIN_ONE)
    else $error("held gain above unity");

  a_done_in_rel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdone_q |-> in_release_q)
    else $error("release done without release");

  a_stop_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stop_request_o) |-> (release_active_o && !attack_active_o))
    else $error("stop request without release state");
`endif

endmodule

FILE: bench/stereo_attack_release_envelope_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the stereo attack/release envelope with cubic gain law.
module stereo_attack_release_envelope_test;
  import sare_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD      = 300;
  localparam int TAIL_CYCLES    = 32;
  localparam int MAX_REPORTS    = 10;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_BEATS    = 200;
  localparam int SHORT_RAMP     = 40;
  localparam logic [COUNT_BITS-1:0]  LEN_MAX    = '1;
  localparam logic [STEP_BITS-1:0]   STEP_ONE   = STEP_BITS'(1 << 24);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7F_FFFF;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h80_0000;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] left;
    logic [SAMPLE_BITS-1:0] right;
    logic                   attack_on;
    logic                   release_on;
    logic                   stop_req;
  } env_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [1:0]                    kind_i;
  logic signed [SAMPLE_BITS-1:0] left_sample_i;
  logic signed [SAMPLE_BITS-1:0] right_sample_i;
  logic                          instant_stop_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic signed [SAMPLE_BITS-1:0] left_out_o;
  logic signed [SAMPLE_BITS-1:0] right_out_o;
  logic                          attack_active_o;
  logic                          release_active_o;
  logic                          stop_request_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [1:0]                    cfg_index_i;
  logic [STEP_BITS-1:0]          cfg_data_i;

  stereo_attack_release_envelope dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .kind_i, .left_sample_i, .right_sample_i, .instant_stop_i,
    .out_valid_o, .out_stall_i, .left_out_o, .right_out_o,
    .attack_active_o, .release_active_o, .stop_request_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  // envelope predictor state
  logic [COUNT_BITS-1:0] ramp_up_len, ramp_down_len, ramp_up_pos, ramp_down_pos;
  logic [STEP_BITS-1:0]  ramp_up_step, ramp_down_step;
  logic [GAIN_BITS-1:0]  gain_hold;
  logic                  rising, falling, muted;

  env_result_t pending_envelope[$];
  int  err_count     = 0;
  int  results_seen  = 0;
  int  beats_sent    = 0;
  bit  src_idle_on   = 1'b1;
  bit  sink_idle_on  = 1'b1;
  int  hold_token    = 0;
  int  hold_seen     = 0;
  int  stall_cnt     = 0;
  int  idle_cycles   = 0;

  function automatic logic [SAMPLE_BITS-1:0] cube_scale(input logic [SAMPLE_BITS-1:0] s,
                                                        input logic [GAIN_BITS-1:0] g);
    logic [63:0] g2, g3;
    longint      p;
    g2 = (64'(g) * 64'(g)) >> GAIN_FRAC;
    g3 = (g2 * 64'(g)) >> GAIN_FRAC;
    p  = longint'($signed(s)) * longint'(g3);
    return SAMPLE_BITS'(p >>> GAIN_FRAC);
  endfunction

  function automatic env_result_t predict_envelope(input logic [1:0] k,
                                                   input logic [SAMPLE_BITS-1:0] l, r,
                                                   input logic inst);
    env_result_t res;
    logic [63:0] gain, dec;
    res = '0;
    case (k)
      KIND_START: begin
        if (ramp_up_len != 0) begin
          ramp_up_pos = '0;
          rising      = 1'b1;
        end
        falling = 1'b0;
        muted   = 1'b0;
      end
      KIND_STOP: begin
        if (ramp_down_len != 0 && !inst) begin
          if (!falling) begin
            if (ramp_up_len == 0) gain_hold = GAIN_ONE;
            ramp_down_pos = '0;
            falling       = 1'b1;
            muted         = 1'b0;
          end
        end else begin
          gain_hold    = '0;
          falling      = 1'b1;
          muted        = 1'b1;
          res.stop_req = 1'b1;
        end
        rising = 1'b0;
      end
      KIND_SAMPLE: begin
        if (rising) begin
          gain = (64'(ramp_up_pos) * 64'(ramp_up_step)) >> ATT_SHIFT;
          if (gain > 64'(GAIN_ONE)) gain = 64'(GAIN_ONE);
          gain_hold   = GAIN_BITS'(gain);
          res.left    = cube_scale(l, gain_hold);
          res.right   = cube_scale(r, gain_hold);
          ramp_up_pos = ramp_up_pos + 1'b1;
          if (ramp_up_pos >= ramp_up_len) rising = 1'b0;
        end else if (falling && !muted) begin
          dec  = (64'(ramp_down_pos) * 64'(gain_hold) * 64'(ramp_down_step)) >> DEC_SHIFT;
          gain = (dec >= 64'(gain_hold)) ? 64'd0 : 64'(gain_hold) - dec;
          res.left      = cube_scale(l, GAIN_BITS'(gain));
          res.right     = cube_scale(r, GAIN_BITS'(gain));
          ramp_down_pos = ramp_down_pos + 1'b1;
          if (64'(ramp_down_pos) + 64'd1 >= 64'(ramp_down_len)) begin
            gain_hold    = '0;
            muted        = 1'b1;
            res.stop_req = 1'b1;
          end
        end else if (!falling) begin
          res.left  = l;
          res.right = r;
        end
      end
      default: ;
    endcase
    res.attack_on  = rising;
    res.release_on = falling;
    return res;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [STEP_BITS-1:0] reciprocal(input logic [COUNT_BITS-1:0] len);
    return (len == 0) ? '0 : STEP_BITS'((32'd1 << 24) / 32'(len));
  endfunction

  // valid stays high from one beat to the next unless a gap is inserted
  task automatic send_beat(input logic [1:0] k, input logic [SAMPLE_BITS-1:0] l, r,
                           input logic inst);
    int gap;
    if (src_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= k;
    left_sample_i  <= l;
    right_sample_i <= r;
    instant_stop_i <= inst;
    do @(posedge clk_i); while (in_stall_o);
    pending_envelope.push_back(predict_envelope(k, l, r, inst));
    beats_sent++;
  endtask

  task automatic send_sample(input logic [SAMPLE_BITS-1:0] l, r);
    send_beat(KIND_SAMPLE, l, r, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_envelope.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [STEP_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ATTACK_LENGTH:  ramp_up_len    = data[COUNT_BITS-1:0];
      CFG_RELEASE_LENGTH: ramp_down_len  = data[COUNT_BITS-1:0];
      CFG_ATTACK_STEP:    ramp_up_step   = data;
      CFG_RELEASE_STEP:   ramp_down_step = data;
      default: ;
    endcase
  endtask

  task automatic load_envelope(input logic [COUNT_BITS-1:0] al, rl,
                               input logic [STEP_BITS-1:0] as, rs);
    write_reg(CFG_ATTACK_LENGTH, STEP_BITS'(al));
    write_reg(CFG_RELEASE_LENGTH, STEP_BITS'(rl));
    write_reg(CFG_ATTACK_STEP, as);
    write_reg(CFG_RELEASE_STEP, rs);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_passthrough_and_mute();
    send_beat(KIND_SAMPLE, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_beat(KIND_SAMPLE, '0, '1, 1'b1);
    send_beat(KIND_UNUSED, SAMPLE_MAX, SAMPLE_MAX, 1'b1);
    send_beat(KIND_START, '0, '0, 1'b0);
    send_beat(KIND_STOP, '0, '0, 1'b0);
    send_beat(KIND_SAMPLE, SAMPLE_MAX, SAMPLE_MIN, 1'b0);
    send_beat(KIND_START, '0, '0, 1'b0);
    wait_drained();
  endtask

  task automatic test_ramps();
    load_envelope(COUNT_BITS'(2), COUNT_BITS'(3),
                  reciprocal(COUNT_BITS'(2)), reciprocal(COUNT_BITS'(3)));
    send_beat(KIND_START, '0, '0, 1'b0);
    repeat (3) send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_beat(KIND_STOP, '0, '0, 1'b0);
    repeat (3) send_sample(SAMPLE_MIN, SAMPLE_MAX);
    // stop during mute is ignored
    send_beat(KIND_STOP, '0, '0, 1'b0);
    send_beat(KIND_START, '0, '0, 1'b0);
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    // stop during attack releases from the attack gain
    send_beat(KIND_STOP, '0, '0, 1'b0);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_beat(KIND_STOP, '0, '0, 1'b1);
    wait_drained();
  endtask

  task automatic test_single_sample_release();
    load_envelope(COUNT_BITS'(0), COUNT_BITS'(1), STEP_ONE, STEP_ONE);
    send_beat(KIND_START, '0, '0, 1'b0);
    send_beat(KIND_STOP, '0, '0, 1'b0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_beat(KIND_START, '0, '0, 1'b0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    load_envelope(COUNT_BITS'(8), COUNT_BITS'(8),
                  reciprocal(COUNT_BITS'(8)), reciprocal(COUNT_BITS'(8)));
    hold_token++;
    send_beat(KIND_START, '0, '0, 1'b0);
    repeat (10) send_sample(pick_sample(), pick_sample());
    send_beat(KIND_STOP, '0, '0, 1'b0);
    repeat (9) send_sample(pick_sample(), pick_sample());
    wait_drained();
  endtask

  task automatic pick_config(input int phase);
    logic [COUNT_BITS-1:0] al, rl;
    logic [STEP_BITS-1:0]  as, rs;
    al = (phase == 2 || $urandom_range(0, 9) == 0) ? '0 : COUNT_BITS'($urandom_range(1, 30));
    rl = (phase == 2 || $urandom_range(0, 9) == 0) ? '0 : COUNT_BITS'($urandom_range(1, 30));
    if (phase == 1) begin
      al = LEN_MAX;
      rl = LEN_MAX;
    end
    as = reciprocal(al);
    rs = reciprocal(rl);
    case ($urandom_range(0, 5))
      0: as = STEP_BITS'($urandom_range(0, 1 << 24));
      1: rs = STEP_BITS'($urandom_range(0, 1 << 24));
      2: begin
        as = STEP_ONE;
        rs = STEP_ONE;
      end
      3: begin
        as = '0;
        rs = '0;
      end
      default: ;
    endcase
    if (phase == 1) as = STEP_ONE;
    load_envelope(al, rl, as, rs);
  endtask

  task automatic test_random_traffic();
    int goal, n;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      src_idle_on  = (phase != 3 && phase < RAND_PHASES - 2);
      sink_idle_on = src_idle_on;
      pick_config(phase);
      if (phase == 4) hold_token++;
      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) begin
        if ($urandom_range(0, 4) != 0) begin
          send_beat(KIND_START, pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
          n = (ramp_up_len < SHORT_RAMP) ? ramp_up_len + $urandom_range(0, 2)
                                         : $urandom_range(1, SHORT_RAMP);
          repeat (n) send_sample(pick_sample(), pick_sample());
          send_beat(KIND_STOP, pick_sample(), pick_sample(), $urandom_range(0, 7) == 0);
          n = (ramp_down_len < SHORT_RAMP) ? ramp_down_len + $urandom_range(0, 2)
                                           : $urandom_range(1, SHORT_RAMP);
          repeat (n) send_sample(pick_sample(), pick_sample());
        end else begin
          repeat ($urandom_range(1, 6))
            send_beat(2'($urandom_range(0, 3)), pick_sample(), pick_sample(),
                      1'($urandom_range(0, 1)));
        end
      end
      wait_drained();
    end
  endtask

  // receiver stall: random bursts plus one long hold per token
  always @(posedge clk_i) begin
    if (stall_cnt > 0) begin
      stall_cnt--;
    end else if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      stall_cnt = LONG_HOLD;
    end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
      stall_cnt = $urandom_range(1, 11);
    end
    out_stall_i <= (stall_cnt > 0);
  end

  always @(posedge clk_i) begin
    env_result_t got, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {left_out_o, right_out_o, attack_active_o, release_active_o, stop_request_o};
      if (pending_envelope.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("ERROR: unexpected result beat: left %h right %h flags %b%b%b",
                   got.left, got.right, got.attack_on, got.release_on, got.stop_req);
      end else begin
        want = pending_envelope.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display({"ERROR: result %0d: expected left %h right %h flags %b%b%b, ",
                      "got left %h right %h flags %b%b%b"}, results_seen,
                     want.left, want.right, want.attack_on, want.release_on, want.stop_req,
                     got.left, got.right, got.attack_on, got.release_on, got.stop_req);
        end
      end
      results_seen++;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_SAMPLE;
    left_sample_i  = '0;
    right_sample_i = '0;
    instant_stop_i = 1'b0;
    out_stall_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_ATTACK_LENGTH;
    cfg_data_i     = '0;
    ramp_up_len    = '0;
    ramp_down_len  = '0;
    ramp_up_step   = '0;
    ramp_down_step = '0;
    ramp_up_pos    = '0;
    ramp_down_pos  = '0;
    gain_hold      = '0;
    rising         = 1'b0;
    falling        = 1'b0;
    muted          = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_passthrough_and_mute();
    test_ramps();
    test_single_sample_release();
    test_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    err_count += pending_envelope.size();
    if (err_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
design/sare_pkg.sv
design/sare_mul.sv
design/sare_seq.sv
design/stereo_attack_release_envelope.sv
bench/stereo_attack_release_envelope_test.sv
